FILE: hdl/rbp_pkg.sv
// shared types and constants for the raw10 2x2 binning packer
package rbp_pkg;

  localparam int GROUP_W   = 40;
  localparam int PIX_W     = 10;
  localparam int SUM_W     = 11;
  localparam int BIN_W     = 12;
  localparam int OUT_W     = 24;
  localparam int GPR_W     = 11;
  localparam int RP_W      = 13;
  localparam int PAIR_W    = 12;
  localparam int MAX_PAIRS = 4096;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int GPR_RESET = 1024;
  localparam int RP_RESET  = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_GROUPS_PER_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PAIRS      = 2'd1;

  typedef struct packed {
    logic [SUM_W-1:0] s1;
    logic [SUM_W-1:0] s0;
  } sums_t;

  typedef struct packed {
    logic second;
    logic eor;
    logic eof;
  } ctl_t;

  localparam int SUMS_W = $bits(sums_t);
  localparam int CTL_W  = $bits(ctl_t);

endpackage

FILE: hdl/raw10_bin2x2_pack12.sv
// top level of the raw10 2x2 binning packer
// Takes one 5-byte RAW10 group (four 10-bit pixels) per clock unless stalled and bins 2x2
// pixel blocks into two 12-bit values per group, packed into 3 bytes. On the first row of
// each row pair the two horizontal pair sums of every group go into a line store and no item
// leaves; on the second row each group gives one output item, with tlast on the last item of
// the row and tuser[0] on the last item of the frame. Sustained rate is one group per clock
// unless the output stalls, set by the single line store port (one write or one read per
// group); items pass the read and output registers. A small queue separates the counters
// from the line store so that output stalls do not stop input at once. Write registers only
// while the block is idle; a write does not restart the row or frame counters.
module raw10_bin2x2_pack12 import rbp_pkg::*; #(
  parameter int MAX_GROUPS  = 1024,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [GROUP_W-1:0]   s_axis_tdata,  // packed_group
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,  // packed_out
  output logic                 m_axis_tlast,  // end_of_row
  output logic [0:0]           m_axis_tuser   // end_of_frame
);

  localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int QW = AW + SUMS_W + CTL_W;

  logic          push;
  logic          push_ready;
  logic [AW-1:0] push_col;
  sums_t         push_sums;
  ctl_t          push_ctl;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_data;
  logic [AW-1:0] q_col;
  sums_t         q_sums;
  ctl_t          q_ctl;

  rbp_front #(
    .MAX_GROUPS (MAX_GROUPS),
    .AW         (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_group   (s_axis_tdata),
    .push       (push),
    .push_ready (push_ready),
    .push_col   (push_col),
    .push_sums  (push_sums),
    .push_ctl   (push_ctl)
  );

  rbp_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  ({push_col, push_sums, push_ctl}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign {q_col, q_sums, q_ctl} = q_data;

  rbp_back #(
    .MAX_GROUPS (MAX_GROUPS),
    .AW         (AW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_col   (q_col),
    .q_sums  (q_sums),
    .q_ctl   (q_ctl),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_eor   (m_axis_tlast),
    .m_eof   (m_axis_tuser[0])
  );

endmodule

FILE: hdl/rbp_front.sv
// front end: config registers, row and pair counters, horizontal pair sums
module rbp_front import rbp_pkg::*; #(
  parameter int MAX_GROUPS = 1024,
  parameter int AW         = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [GROUP_W-1:0]   in_group,
  output logic                 push,
  input  logic                 push_ready,
  output logic [AW-1:0]        push_col,
  output sums_t                push_sums,
  output ctl_t                 push_ctl
);

  localparam int GW_A = $clog2(MAX_GROUPS + 1);
  localparam int GW   = (GW_A > GPR_W) ? GW_A : GPR_W;

  logic [GPR_W-1:0]  groups_per_row;
  logic [RP_W-1:0]   row_pairs;
  logic [AW-1:0]     column_count;
  logic              second_row;
  logic [PAIR_W-1:0] pair_count;

  logic [GW-1:0]     gval;
  logic [GW-1:0]     gmax;
  logic [RP_W-1:0]   pmax;
  logic              last_col;
  logic              last_pair;
  logic [PIX_W-1:0]  pix [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_row <= GPR_W'(GPR_RESET);
      row_pairs      <= RP_W'(RP_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GROUPS_PER_ROW: groups_per_row <= cfg_data[GPR_W-1:0];
        REG_ROW_PAIRS:      row_pairs      <= cfg_data[RP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp limits: zero acts as one, above the limit acts as the limit
  always_comb begin
    gval = GW'(groups_per_row);
    if (gval == '0) begin
      gmax = GW'(1);
    end else if (gval > GW'(MAX_GROUPS)) begin
      gmax = GW'(MAX_GROUPS);
    end else begin
      gmax = gval;
    end
    if (row_pairs == '0) begin
      pmax = RP_W'(1);
    end else if (row_pairs > RP_W'(MAX_PAIRS)) begin
      pmax = RP_W'(MAX_PAIRS);
    end else begin
      pmax = row_pairs;
    end
  end

  assign last_col  = (GW'(column_count) + GW'(1)) >= gmax;
  assign last_pair = (RP_W'(pair_count) + RP_W'(1)) >= pmax;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pix[k] = {in_group[8*k +: 8], in_group[32 + 2*k +: 2]};
    end
  end

  assign in_ready            = push_ready;
  assign push                = in_valid && push_ready;
  assign push_col            = column_count;
  assign push_sums.s0        = SUM_W'(pix[0]) + SUM_W'(pix[1]);
  assign push_sums.s1        = SUM_W'(pix[2]) + SUM_W'(pix[3]);
  assign push_ctl.second     = second_row;
  assign push_ctl.eor        = last_col;
  assign push_ctl.eof        = last_col && last_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      second_row   <= 1'b0;
      pair_count   <= '0;
    end else if (push) begin
      if (last_col) begin
        column_count <= '0;
        if (second_row) begin
          second_row <= 1'b0;
          if (last_pair) begin
            pair_count <= '0;
          end else begin
            pair_count <= pair_count + PAIR_W'(1);
          end
        end else begin
          second_row <= 1'b1;
        end
      end else begin
        column_count <= column_count + AW'(1);
      end
    end
  end

endmodule

FILE: hdl/rbp_queue.sv
// short fifo between front end and back end
module rbp_queue import rbp_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CW'(1))
    else $error("queue count did not grow on push");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push && count == CW'(1) |=> !pop_valid)
    else $error("queue not empty after last pop");

endmodule

FILE: hdl/rbp_back.sv
// back end: line store, vertical add, 12-bit packing and output register
module rbp_back import rbp_pkg::*; #(
  parameter int MAX_GROUPS = 1024,
  parameter int AW         = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic [AW-1:0]      q_col,
  input  sums_t              q_sums,
  input  ctl_t               q_ctl,
  output logic               m_valid,
  input  logic               m_ready,
  output logic [OUT_W-1:0]   m_data,
  output logic               m_eor,
  output logic               m_eof
);

  logic [SUMS_W-1:0] line_sums [MAX_GROUPS];
  logic [SUMS_W-1:0] rd_data;
  logic              v2;
  sums_t             sums2;
  logic              eor2;
  logic              eof2;
  logic              out_free;
  logic              adv2;
  sums_t             stored;
  logic [BIN_W-1:0]  g0;
  logic [BIN_W-1:0]  g1;

  assign out_free = !m_valid || m_ready;
  assign adv2     = !v2 || out_free;
  assign q_pop    = q_valid && adv2;

  // first row writes, second row reads the same column
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_ctl.second) begin
        rd_data <= line_sums[q_col];
      end else begin
        line_sums[q_col] <= q_sums;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= q_pop && q_ctl.second;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sums2 <= q_sums;
      eor2  <= q_ctl.eor;
      eof2  <= q_ctl.eof;
    end
  end

  assign stored = rd_data;
  assign g0     = BIN_W'(sums2.s0) + BIN_W'(stored.s0);
  assign g1     = BIN_W'(sums2.s1) + BIN_W'(stored.s1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_free) begin
      m_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v2) begin
      m_data <= {g1[3:0], g0[3:0], g1[BIN_W-1:4], g0[BIN_W-1:4]};
      m_eor  <= eor2;
      m_eof  <= eof2;
    end
  end

  a_eof_ends_row: assert property (@(posedge clk) disable iff (rst) m_valid && m_eof |-> m_eor)
    else $error("end of frame without end of row");
  a_read_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_ctl.second |=> v2)
    else $error("second row item lost at read stage");
  a_read_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !out_free |=> v2 && $stable(sums2) && $stable(rd_data))
    else $error("read stage changed while stalled");

endmodule
